### sv/tfpc8_pkg.sv
// Package for the telegram frame parser with CRC-8 check.
// Holds the frame layout constants, status codes and the CRC-8 byte update.
// No dependencies.
package tfpc8_pkg;

    localparam int unsigned HeaderLen = 5;
    localparam int unsigned MinFrame  = 6;
    localparam int unsigned PosWidth  = 9;

    localparam logic [7:0]          CrcPoly = 8'h07;
    localparam logic [PosWidth-1:0] PosMax  = {PosWidth{1'b1}};

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TOO_SHORT = 3'd1,
        STATUS_WRONG_PROT = 3'd2,
        STATUS_TRUNCATED = 3'd3,
        STATUS_CRC_ERROR = 3'd4
    } status_t;

    // CRC-8, MSB first, no reflection, no final XOR.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            if (c[7] ^ d[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/telegram_frame_parser_crc8_core.sv
// Top level of the telegram frame parser with CRC-8 check.
// Depends on tfpc8_pkg for layout constants, status codes and the CRC update.
//
// The block takes one frame byte per beat and returns one result beat for every
// input beat, in the cycle after acceptance, at a sustained rate of one byte per
// clock. Each byte goes through the header capture, the unrolled CRC-8 update
// and the status check combinationally into the result register; s_ready
// stays high whenever that register is empty or being drained, so the input
// only stalls while a result waits for m_ready. Header fields, CRC and status
// appear on the beat that carries frame_end and read zero on all other beats.
// The expected protocol id resets to 1 and is changed by a cfg_we write.
module telegram_frame_parser_crc8_core
    import tfpc8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_frame_end,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_byte,
    output logic       m_frame_done,
    output logic [2:0] m_status,
    output logic [7:0] m_telegram_type,
    output logic [7:0] m_sender_address,
    output logic [7:0] m_receiver_address,
    output logic [7:0] m_payload_length,
    output logic [7:0] m_received_crc,
    output logic [7:0] m_computed_crc
);

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_done;
        status_t    status;
        logic [7:0] telegram_type;
        logic [7:0] sender_address;
        logic [7:0] receiver_address;
        logic [7:0] payload_length;
        logic [7:0] received_crc;
        logic [7:0] computed_crc;
    } result_t;

    typedef struct packed {
        logic [PosWidth-1:0] pos;
        logic [7:0]          crc;
        logic [7:0]          prot;
        logic [7:0]          ttype;
        logic [7:0]          sender;
        logic [7:0]          receiver;
        logic [7:0]          length;
        logic [7:0]          crc_seen;
        logic                crc_present;
    } frame_t;

    logic [7:0] protocol_id_reg;
    frame_t     frame_reg;
    frame_t     frame_next;
    frame_t     upd;
    result_t    result_reg;
    result_t    result_next;
    logic       m_valid_reg;
    logic       accept;

    logic [PosWidth-1:0] crc_pos;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign crc_pos = PosWidth'(HeaderLen) + {1'b0, frame_reg.length};

    always_comb begin
        upd         = frame_reg;
        result_next = '0;

        if (frame_reg.pos < PosWidth'(HeaderLen)) begin
            case (frame_reg.pos[2:0])
                3'd0:    upd.prot     = s_rx_byte;
                3'd1:    upd.ttype    = s_rx_byte;
                3'd2:    upd.sender   = s_rx_byte;
                3'd3:    upd.receiver = s_rx_byte;
                default: upd.length   = s_rx_byte;
            endcase
            upd.crc = crc8_update(frame_reg.crc, s_rx_byte);
        end else if (frame_reg.pos < crc_pos) begin
            result_next.payload_valid = 1'b1;
            result_next.payload_byte  = s_rx_byte;
            upd.crc = crc8_update(frame_reg.crc, s_rx_byte);
        end else if (frame_reg.pos == crc_pos) begin
            upd.crc_seen    = s_rx_byte;
            upd.crc_present = 1'b1;
        end

        if (frame_reg.pos != PosMax) begin
            upd.pos = frame_reg.pos + 1'b1;
        end

        frame_next = upd;

        if (s_frame_end) begin
            result_next.frame_done = 1'b1;
            if (frame_reg.pos < PosWidth'(MinFrame - 1)) begin
                result_next.status = STATUS_TOO_SHORT;
            end else if (upd.prot != protocol_id_reg) begin
                result_next.status = STATUS_WRONG_PROT;
            end else if (!upd.crc_present) begin
                result_next.status = STATUS_TRUNCATED;
            end else if (upd.crc_seen != upd.crc) begin
                result_next.status = STATUS_CRC_ERROR;
            end else begin
                result_next.status = STATUS_OK;
            end
            result_next.telegram_type    = upd.ttype;
            result_next.sender_address   = upd.sender;
            result_next.receiver_address = upd.receiver;
            result_next.payload_length   = upd.length;
            result_next.received_crc     = upd.crc_present ? upd.crc_seen : 8'h00;
            result_next.computed_crc     = upd.crc;
            frame_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_id_reg <= 8'h01;
            frame_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                protocol_id_reg <= cfg_wdata;
            end
            if (accept) begin
                frame_reg   <= frame_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_payload_valid    = result_reg.payload_valid;
    assign m_payload_byte     = result_reg.payload_byte;
    assign m_frame_done       = result_reg.frame_done;
    assign m_status           = result_reg.status;
    assign m_telegram_type    = result_reg.telegram_type;
    assign m_sender_address   = result_reg.sender_address;
    assign m_receiver_address = result_reg.receiver_address;
    assign m_payload_length   = result_reg.payload_length;
    assign m_received_crc     = result_reg.received_crc;
    assign m_computed_crc     = result_reg.computed_crc;

endmodule
